FILE: src/ccoll_pkg.sv
// shared types, widths and the divider step for the circle/segment collision unit
// no dependencies
package ccoll_pkg;

    localparam int CW   = 24;   // coordinate width, signed Q12.12
    localparam int DW   = 25;   // coordinate difference width
    localparam int RW   = 23;   // radius width
    localparam int R2W  = 46;   // squared radius width
    localparam int SQW  = 48;   // square of a difference
    localparam int LW   = 49;   // sum of two squares, also divisor width
    localparam int DOTW = 50;   // signed dot product
    localparam int AXW  = 24;   // magnitude of a direction component
    localparam int NUMW = 73;   // magnitude of component times dot
    localparam int QW   = 25;   // quotient bits, also divider stage count
    localparam int PW   = 27;   // unwrapped projected coordinate
    localparam int EW   = 28;   // projected point minus centre

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;

    typedef struct packed {
        coord_t           cx;
        coord_t           cy;
        coord_t           x1;
        coord_t           y1;
        coord_t           x2;
        coord_t           y2;
        logic [R2W-1:0]   r2;
        logic             ends;
        logic             e1;
        logic             e2;
        logic             zero;
        logic             negx;
        logic             negy;
    } ccoll_side_t;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [LW:0] div_step(input logic [LW-1:0] rem, input logic b,
                                             input logic [LW-1:0] den);
        logic [LW:0] t;
        logic [LW:0] d;
        t = {rem, b};
        d = {1'b0, den};
        if (t >= d)
            div_step = {1'b1, LW'(t - d)};
        else
            div_step = {1'b0, t[LW-1:0]};
    endfunction

endpackage

FILE: src/ccoll_div.sv
// pipelined restoring divider, one quotient bit per stage, x and y in parallel
// depends on ccoll_pkg; carries the query sideband alongside the quotients
module ccoll_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     v_in,
    input  logic [ccoll_pkg::NUMW-1:0] numx,
    input  logic [ccoll_pkg::NUMW-1:0] numy,
    input  logic [ccoll_pkg::LW-1:0] den,
    input  ccoll_pkg::ccoll_side_t   side_in,
    output logic                     v_out,
    output logic [ccoll_pkg::QW-1:0] qx,
    output logic [ccoll_pkg::QW-1:0] qy,
    output ccoll_pkg::ccoll_side_t   side_out
);
    import ccoll_pkg::*;

    logic [QW-1:0] v_reg;
    logic [LW-1:0] remx_reg [QW];
    logic [LW-1:0] remy_reg [QW];
    logic [LW-1:0] den_reg  [QW];
    logic [QW-1:0] lowx_reg [QW];
    logic [QW-1:0] lowy_reg [QW];
    logic [QW-1:0] qx_reg   [QW];
    logic [QW-1:0] qy_reg   [QW];
    ccoll_side_t   side_reg [QW];

    logic [LW-1:0] remx_cur [QW];
    logic [LW-1:0] remy_cur [QW];
    logic [LW-1:0] den_cur  [QW];
    logic [QW-1:0] lowx_cur [QW];
    logic [QW-1:0] lowy_cur [QW];
    logic [QW-1:0] qx_cur   [QW];
    logic [QW-1:0] qy_cur   [QW];
    ccoll_side_t   side_cur [QW];
    logic [LW:0]   stepx    [QW];
    logic [LW:0]   stepy    [QW];

    always_comb
    begin
        // the high numerator bits start below the divisor, so the quotient fits QW bits
        remx_cur[0] = LW'(numx[NUMW-1:QW]);
        remy_cur[0] = LW'(numy[NUMW-1:QW]);
        lowx_cur[0] = numx[QW-1:0];
        lowy_cur[0] = numy[QW-1:0];
        den_cur[0]  = den;
        qx_cur[0]   = '0;
        qy_cur[0]   = '0;
        side_cur[0] = side_in;
        for (int k = 1; k < QW; k++)
        begin
            remx_cur[k] = remx_reg[k-1];
            remy_cur[k] = remy_reg[k-1];
            lowx_cur[k] = lowx_reg[k-1];
            lowy_cur[k] = lowy_reg[k-1];
            den_cur[k]  = den_reg[k-1];
            qx_cur[k]   = qx_reg[k-1];
            qy_cur[k]   = qy_reg[k-1];
            side_cur[k] = side_reg[k-1];
        end
        for (int k = 0; k < QW; k++)
        begin
            stepx[k] = div_step(remx_cur[k], lowx_cur[k][QW-1], den_cur[k]);
            stepy[k] = div_step(remy_cur[k], lowy_cur[k][QW-1], den_cur[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QW-2:0], v_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                remx_reg[k] <= stepx[k][LW-1:0];
                remy_reg[k] <= stepy[k][LW-1:0];
                lowx_reg[k] <= {lowx_cur[k][QW-2:0], 1'b0};
                lowy_reg[k] <= {lowy_cur[k][QW-2:0], 1'b0};
                qx_reg[k]   <= {qx_cur[k][QW-2:0], stepx[k][LW]};
                qy_reg[k]   <= {qy_cur[k][QW-2:0], stepy[k][LW]};
                den_reg[k]  <= den_cur[k];
                side_reg[k] <= side_cur[k];
            end
        end
    end

    assign v_out    = v_reg[QW-1];
    assign qx       = qx_reg[QW-1];
    assign qy       = qy_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

FILE: src/circle_segment_collision_unit.sv
// circle versus line segment collision, fully pipelined top level
// depends on ccoll_pkg and ccoll_div
//
// A new query can be taken every cycle unless item_stall is high, giving one result;
// it passes five stages of differences, squares, dot product and split products,
// a 25-stage divider producing one quotient bit per stage for each axis, then
// three stages for the bounding box test, the distance squares and the final
// select into the output register. When a result is held by result_stall the
// whole pipeline holds and item_stall is raised in the same cycle.
module circle_segment_collision_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  ccoll_pkg::coord_t     center_x,
    input  ccoll_pkg::coord_t     center_y,
    input  logic [ccoll_pkg::RW-1:0] radius,
    input  ccoll_pkg::coord_t     seg_x1,
    input  ccoll_pkg::coord_t     seg_y1,
    input  ccoll_pkg::coord_t     seg_x2,
    input  ccoll_pkg::coord_t     seg_y2,
    input  logic                  check_ends,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  hit,
    output ccoll_pkg::coord_t     closest_x,
    output ccoll_pkg::coord_t     closest_y,
    output ccoll_pkg::diff_t      push_x,
    output ccoll_pkg::diff_t      push_y
);
    import ccoll_pkg::*;

    logic en;

    // stage 1: differences
    logic          s1_v_reg;
    ccoll_side_t   s1_side_reg;
    logic [RW-1:0] s1_r_reg;
    diff_t         s1_wx1_reg, s1_wy1_reg, s1_wx2_reg, s1_wy2_reg, s1_dx_reg, s1_dy_reg;
    ccoll_side_t   s1_side_next;

    // stage 2: squares and products
    logic             s2_v_reg;
    ccoll_side_t      s2_side_reg;
    logic [SQW-1:0]   s2_q1x_reg, s2_q1y_reg, s2_q2x_reg, s2_q2y_reg, s2_ddx_reg, s2_ddy_reg;
    logic signed [DOTW-1:0] s2_pdx_reg, s2_pdy_reg;
    diff_t            s2_dx_reg, s2_dy_reg;
    logic signed [2*DW-1:0] q1x_full, q1y_full, q2x_full, q2y_full, ddx_full, ddy_full;
    ccoll_side_t      s2_side_next;

    // stage 3: sums, endpoint tests
    logic                   s3_v_reg;
    ccoll_side_t            s3_side_reg;
    logic [LW-1:0]          s3_len2_reg;
    logic signed [DOTW-1:0] s3_dot_reg;
    diff_t                  s3_dx_reg, s3_dy_reg;
    ccoll_side_t            s3_side_next;

    // stage 4: magnitudes and split products
    logic             s4_v_reg;
    ccoll_side_t      s4_side_reg;
    logic [LW-1:0]    s4_len2_reg;
    logic [AXW+QW-1:0] s4_pxl_reg, s4_pyl_reg;
    logic [2*AXW-1:0] s4_pxh_reg, s4_pyh_reg;
    logic [LW-1:0]    adot;
    diff_t            adx_full, ady_full;
    logic [AXW-1:0]   adx, ady;
    ccoll_side_t      s4_side_next;

    // stage 5: divider operands
    logic             s5_v_reg;
    ccoll_side_t      s5_side_reg;
    logic [NUMW-1:0]  s5_numx_reg, s5_numy_reg;
    logic [LW-1:0]    s5_den_reg;

    // divider output
    logic          dv_v;
    logic [QW-1:0] dv_qx, dv_qy;
    ccoll_side_t   dv_side;

    // stage E1: projected point and box test
    logic                 e1_v_reg;
    ccoll_side_t          e1_side_reg;
    logic signed [PW-1:0] e1_qx_reg, e1_qy_reg;
    logic                 e1_inbox_reg;
    logic signed [EW-1:0] e1_ex_reg, e1_ey_reg;
    logic signed [PW-1:0] qx_s, qy_s, qx_off, qy_off, lox, hix, loy, hiy;

    // stage E2: distance squares
    logic           e2_v_reg;
    ccoll_side_t    e2_side_reg;
    coord_t         e2_qx_reg, e2_qy_reg;
    diff_t          e2_ex_reg, e2_ey_reg;
    logic           e2_inbox_reg;
    logic [SQW-1:0] e2_ex2_reg, e2_ey2_reg;
    logic signed [2*DW-1:0] ex2_full, ey2_full;

    // output register
    logic   out_v_reg;
    logic   hit_reg, hit_next;
    coord_t cx_reg, cy_reg, cx_next, cy_next;
    diff_t  px_reg, py_reg, px_next, py_next;
    logic   proj_hit;

    assign en         = !(out_v_reg && result_stall);
    assign item_stall = out_v_reg && result_stall;

    // ---------------- valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            e1_v_reg  <= 1'b0;
            e2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= item_valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            e1_v_reg  <= dv_v;
            e2_v_reg  <= e1_v_reg;
            out_v_reg <= e2_v_reg;
        end
    end

    // ---------------- front end
    always_comb
    begin
        s1_side_next      = '0;
        s1_side_next.cx   = center_x;
        s1_side_next.cy   = center_y;
        s1_side_next.x1   = seg_x1;
        s1_side_next.y1   = seg_y1;
        s1_side_next.x2   = seg_x2;
        s1_side_next.y2   = seg_y2;
        s1_side_next.ends = check_ends;

        q1x_full = s1_wx1_reg * s1_wx1_reg;
        q1y_full = s1_wy1_reg * s1_wy1_reg;
        q2x_full = s1_wx2_reg * s1_wx2_reg;
        q2y_full = s1_wy2_reg * s1_wy2_reg;
        ddx_full = s1_dx_reg * s1_dx_reg;
        ddy_full = s1_dy_reg * s1_dy_reg;
        s2_side_next    = s1_side_reg;
        s2_side_next.r2 = R2W'(s1_r_reg) * R2W'(s1_r_reg);

        s3_side_next    = s2_side_reg;
        s3_side_next.e1 = (LW'(s2_q1x_reg) + LW'(s2_q1y_reg)) <= LW'(s2_side_reg.r2);
        s3_side_next.e2 = (LW'(s2_q2x_reg) + LW'(s2_q2y_reg)) <= LW'(s2_side_reg.r2);

        adot     = s3_dot_reg[DOTW-1] ? LW'(-s3_dot_reg) : LW'(s3_dot_reg);
        adx_full = s3_dx_reg[DW-1] ? -s3_dx_reg : s3_dx_reg;
        ady_full = s3_dy_reg[DW-1] ? -s3_dy_reg : s3_dy_reg;
        adx      = adx_full[AXW-1:0];
        ady      = ady_full[AXW-1:0];
        s4_side_next      = s3_side_reg;
        s4_side_next.zero = (s3_len2_reg == '0);
        s4_side_next.negx = s3_dx_reg[DW-1] ^ s3_dot_reg[DOTW-1];
        s4_side_next.negy = s3_dy_reg[DW-1] ^ s3_dot_reg[DOTW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            s1_r_reg    <= radius;
            s1_wx1_reg  <= DW'(center_x) - DW'(seg_x1);
            s1_wy1_reg  <= DW'(center_y) - DW'(seg_y1);
            s1_wx2_reg  <= DW'(center_x) - DW'(seg_x2);
            s1_wy2_reg  <= DW'(center_y) - DW'(seg_y2);
            s1_dx_reg   <= DW'(seg_x2) - DW'(seg_x1);
            s1_dy_reg   <= DW'(seg_y2) - DW'(seg_y1);

            s2_side_reg <= s2_side_next;
            s2_q1x_reg  <= q1x_full[SQW-1:0];
            s2_q1y_reg  <= q1y_full[SQW-1:0];
            s2_q2x_reg  <= q2x_full[SQW-1:0];
            s2_q2y_reg  <= q2y_full[SQW-1:0];
            s2_ddx_reg  <= ddx_full[SQW-1:0];
            s2_ddy_reg  <= ddy_full[SQW-1:0];
            s2_pdx_reg  <= s1_wx1_reg * s1_dx_reg;
            s2_pdy_reg  <= s1_wy1_reg * s1_dy_reg;
            s2_dx_reg   <= s1_dx_reg;
            s2_dy_reg   <= s1_dy_reg;

            s3_side_reg <= s3_side_next;
            s3_len2_reg <= LW'(s2_ddx_reg) + LW'(s2_ddy_reg);
            s3_dot_reg  <= s2_pdx_reg + s2_pdy_reg;
            s3_dx_reg   <= s2_dx_reg;
            s3_dy_reg   <= s2_dy_reg;

            s4_side_reg <= s4_side_next;
            s4_len2_reg <= s3_len2_reg;
            s4_pxl_reg  <= (AXW+QW)'(adx) * (AXW+QW)'(adot[QW-1:0]);
            s4_pyl_reg  <= (AXW+QW)'(ady) * (AXW+QW)'(adot[QW-1:0]);
            s4_pxh_reg  <= (2*AXW)'(adx) * (2*AXW)'(adot[LW-1:QW]);
            s4_pyh_reg  <= (2*AXW)'(ady) * (2*AXW)'(adot[LW-1:QW]);

            s5_side_reg <= s4_side_reg;
            s5_numx_reg <= NUMW'(s4_pxl_reg) + {s4_pxh_reg, {QW{1'b0}}};
            s5_numy_reg <= NUMW'(s4_pyl_reg) + {s4_pyh_reg, {QW{1'b0}}};
            // a zero-length segment never uses the quotient
            s5_den_reg  <= s4_side_reg.zero ? LW'(1) : s4_len2_reg;
        end
    end

    ccoll_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .v_in     (s5_v_reg),
        .numx     (s5_numx_reg),
        .numy     (s5_numy_reg),
        .den      (s5_den_reg),
        .side_in  (s5_side_reg),
        .v_out    (dv_v),
        .qx       (dv_qx),
        .qy       (dv_qy),
        .side_out (dv_side)
    );

    // ---------------- back end
    always_comb
    begin
        qx_off = dv_side.negx ? -PW'(dv_qx) : PW'(dv_qx);
        qy_off = dv_side.negy ? -PW'(dv_qy) : PW'(dv_qy);
        qx_s   = PW'(dv_side.x1) + qx_off;
        qy_s   = PW'(dv_side.y1) + qy_off;
        lox    = (dv_side.x1 < dv_side.x2) ? PW'(dv_side.x1) : PW'(dv_side.x2);
        hix    = (dv_side.x1 < dv_side.x2) ? PW'(dv_side.x2) : PW'(dv_side.x1);
        loy    = (dv_side.y1 < dv_side.y2) ? PW'(dv_side.y1) : PW'(dv_side.y2);
        hiy    = (dv_side.y1 < dv_side.y2) ? PW'(dv_side.y2) : PW'(dv_side.y1);

        ex2_full = $signed(e1_ex_reg[DW-1:0]) * $signed(e1_ex_reg[DW-1:0]);
        ey2_full = $signed(e1_ey_reg[DW-1:0]) * $signed(e1_ey_reg[DW-1:0]);

        proj_hit = e2_inbox_reg && !e2_side_reg.zero
                   && ((LW'(e2_ex2_reg) + LW'(e2_ey2_reg)) < LW'(e2_side_reg.r2));

        hit_next = 1'b0;
        cx_next  = '0;
        cy_next  = '0;
        px_next  = '0;
        py_next  = '0;
        if (e2_side_reg.ends && e2_side_reg.e1)
        begin
            hit_next = 1'b1;
            cx_next  = e2_side_reg.x1;
            cy_next  = e2_side_reg.y1;
            px_next  = DW'(e2_side_reg.cx) - DW'(e2_side_reg.x1);
            py_next  = DW'(e2_side_reg.cy) - DW'(e2_side_reg.y1);
        end
        else if (e2_side_reg.ends && e2_side_reg.e2)
        begin
            hit_next = 1'b1;
            cx_next  = e2_side_reg.x2;
            cy_next  = e2_side_reg.y2;
            px_next  = DW'(e2_side_reg.cx) - DW'(e2_side_reg.x2);
            py_next  = DW'(e2_side_reg.cy) - DW'(e2_side_reg.y2);
        end
        else if (proj_hit)
        begin
            hit_next = 1'b1;
            cx_next  = e2_qx_reg;
            cy_next  = e2_qy_reg;
            px_next  = -e2_ex_reg;
            py_next  = -e2_ey_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_side_reg  <= dv_side;
            e1_qx_reg    <= qx_s;
            e1_qy_reg    <= qy_s;
            e1_inbox_reg <= !(qx_s < lox || qx_s > hix || qy_s < loy || qy_s > hiy);
            e1_ex_reg    <= EW'(qx_s) - EW'(dv_side.cx);
            e1_ey_reg    <= EW'(qy_s) - EW'(dv_side.cy);

            e2_side_reg  <= e1_side_reg;
            e2_qx_reg    <= e1_qx_reg[CW-1:0];
            e2_qy_reg    <= e1_qy_reg[CW-1:0];
            e2_ex_reg    <= e1_ex_reg[DW-1:0];
            e2_ey_reg    <= e1_ey_reg[DW-1:0];
            e2_inbox_reg <= e1_inbox_reg;
            e2_ex2_reg   <= ex2_full[SQW-1:0];
            e2_ey2_reg   <= ey2_full[SQW-1:0];

            hit_reg <= hit_next;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
        end
    end

    assign result_valid = out_v_reg;
    assign hit          = hit_reg;
    assign closest_x    = cx_reg;
    assign closest_y    = cy_reg;
    assign push_x       = px_reg;
    assign push_y       = py_reg;

    // a miss carries all-zero result fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !hit) |-> (closest_x == '0 && closest_y == '0
                                    && push_x == '0 && push_y == '0))
        else $error("miss transaction with nonzero fields");

    // a projection inside the box lies within 25 bits of the centre
    a_inbox_range: assert property (@(posedge clk) disable iff (!rst_n)
        (e1_v_reg && e1_inbox_reg) |-> (e1_ex_reg[EW-1:DW-1] == '0
                                         || e1_ex_reg[EW-1:DW-1] == '1))
        else $error("in-box projection out of range");

    // a held result freezes the pipeline from its first stage to stage E2
    a_hold_front: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && result_stall) |=> ($stable(s1_v_reg) && $stable(e2_v_reg)))
        else $error("pipeline advanced under stall");

endmodule
